// ===== rtl/i2cmbe_pkg.sv =====
// Package with the shared types, codes and helpers of the I2C master bit engine.
package i2cmbe_pkg;

  localparam int HOLD_W     = 16;  // hold counter width, 4 to 32
  localparam int HALF_W     = 16;
  localparam int TIMEOUT_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [HALF_W-1:0]    HALF_RESET    = HALF_W'(10);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(250);
  localparam logic [3:0]           FAIL_MARK     = 4'd8;
  localparam logic [3:0]           BITS_PER_BYTE = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_STOP  = 3'd1,
    KIND_WRITE = 3'd2,
    KIND_READ  = 3'd3,
    KIND_ACK   = 3'd4,
    KIND_TICK  = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ST_A     = 4'd1,
    PH_ST_B     = 4'd2,
    PH_SP_A     = 4'd3,
    PH_SP_B     = 4'd4,
    PH_WR_SETUP = 4'd5,
    PH_WR_HIGH  = 4'd6,
    PH_WR_LOW   = 4'd7,
    PH_WA_HOLD  = 4'd8,
    PH_WA_POLL  = 4'd9,
    PH_RD_PRE   = 4'd10,
    PH_RD_HIGH  = 4'd11,
    PH_RD_POST  = 4'd12,
    PH_AK_PRE   = 4'd13,
    PH_AK_HIGH  = 4'd14,
    PH_AK_LOW   = 4'd15
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_ack;
    logic       rejected;
  } res_t;

  localparam longint unsigned HOLD_CAP = (64'd1 << HOLD_W) - 64'd1;

  // Hold limit: zero acts as one, and the value saturates at what the counter holds.
  function automatic logic [HOLD_W-1:0] hold_limit(input logic [HALF_W-1:0] half);
    longint unsigned h;
    h = 64'(half);
    if (h == 64'd0) begin
      h = 64'd1;
    end
    if (h > HOLD_CAP) begin
      h = HOLD_CAP;
    end
    return HOLD_W'(h);
  endfunction

endpackage

// ===== rtl/i2cmbe_if.sv =====
// Valid/ready channel interfaces for the command input and the result output.
interface i2cmbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       ack_level;
  logic       sda_sample;

  modport source (output valid, kind, data_byte, ack_level, sda_sample, input ready);
  modport sink (input valid, kind, data_byte, ack_level, sda_sample, output ready);
endinterface

interface i2cmbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       no_ack;
  logic       rejected;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_data, no_ack, rejected, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                read_data, no_ack, rejected, output ready);
endinterface

// ===== rtl/i2cmbe_core.sv =====
// Sequencing state, configuration registers and per-item update of the bit engine.
module i2cmbe_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  i2cmbe_pkg::item_t                item,
  input  logic                             cfg_we,
  input  logic [i2cmbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cmbe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output i2cmbe_pkg::res_t                 res
);

  logic [i2cmbe_pkg::HALF_W-1:0]    half_r;
  logic [i2cmbe_pkg::TIMEOUT_W-1:0] timeout_r;

  i2cmbe_pkg::phase_t            phase_r, phase_nxt;
  logic [3:0]                    bit_r, bit_nxt, bit_inc;
  logic [7:0]                    shift_r, shift_nxt;
  logic [i2cmbe_pkg::HOLD_W-1:0] hold_r, hold_nxt, hold_inc, limit;
  logic [7:0]                    poll_r, poll_nxt;
  logic                          scl_r, scl_nxt;
  logic                          sda_r, sda_nxt;
  logic                          drive_r, drive_nxt;
  logic [7:0]                    last_read_r, last_read_nxt;
  logic                          done, nack, rej, is_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= i2cmbe_pkg::HALF_RESET;
      timeout_r <= i2cmbe_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cmbe_pkg::REG_HALF_PERIOD: half_r    <= cfg_wdata[i2cmbe_pkg::HALF_W-1:0];
        i2cmbe_pkg::REG_ACK_TIMEOUT: timeout_r <= cfg_wdata[i2cmbe_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit    = i2cmbe_pkg::hold_limit(half_r);
  assign hold_inc = hold_r + 1'b1;
  assign bit_inc  = bit_r + 1'b1;
  assign is_cmd   = (item.kind == i2cmbe_pkg::KIND_START) || (item.kind == i2cmbe_pkg::KIND_STOP)
                 || (item.kind == i2cmbe_pkg::KIND_WRITE) || (item.kind == i2cmbe_pkg::KIND_READ)
                 || (item.kind == i2cmbe_pkg::KIND_ACK);

  always_comb begin
    phase_nxt     = phase_r;
    bit_nxt       = bit_r;
    shift_nxt     = shift_r;
    hold_nxt      = hold_r;
    poll_nxt      = poll_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    drive_nxt     = drive_r;
    last_read_nxt = last_read_r;
    done          = 1'b0;
    nack          = 1'b0;
    rej           = 1'b0;
    if (accept && is_cmd) begin
      if (phase_r != i2cmbe_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        hold_nxt = '0;
        poll_nxt = '0;
        bit_nxt  = '0;
        case (i2cmbe_pkg::kind_t'(item.kind))
          i2cmbe_pkg::KIND_START: begin
            drive_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1;
            phase_nxt = i2cmbe_pkg::PH_ST_A;
          end
          i2cmbe_pkg::KIND_STOP: begin
            drive_nxt = 1'b1; sda_nxt = 1'b0; scl_nxt = 1'b1;
            phase_nxt = i2cmbe_pkg::PH_SP_A;
          end
          i2cmbe_pkg::KIND_WRITE: begin
            drive_nxt = 1'b1; scl_nxt = 1'b0;
            sda_nxt   = item.data_byte[7];
            shift_nxt = {item.data_byte[6:0], 1'b0};
            phase_nxt = i2cmbe_pkg::PH_WR_SETUP;
          end
          i2cmbe_pkg::KIND_READ: begin
            drive_nxt = 1'b0;
            shift_nxt = '0;
            phase_nxt = i2cmbe_pkg::PH_RD_PRE;
          end
          default: begin
            drive_nxt = 1'b1; scl_nxt = 1'b0;
            shift_nxt = {7'd0, item.ack_level};
            phase_nxt = i2cmbe_pkg::PH_AK_PRE;
          end
        endcase
      end
    end else if (accept && item.kind == i2cmbe_pkg::KIND_TICK
                 && phase_r != i2cmbe_pkg::PH_IDLE) begin
      if (phase_r == i2cmbe_pkg::PH_WA_POLL) begin
        // Acknowledge poll: one SDA sample per tick until low or timeout.
        if (!item.sda_sample) begin
          scl_nxt   = 1'b0;
          phase_nxt = i2cmbe_pkg::PH_IDLE;
          done      = 1'b1;
        end else if (poll_r >= timeout_r) begin
          drive_nxt = 1'b1; sda_nxt = 1'b0; scl_nxt = 1'b1;
          bit_nxt   = i2cmbe_pkg::FAIL_MARK;
          hold_nxt  = '0;
          phase_nxt = i2cmbe_pkg::PH_SP_A;
        end else begin
          poll_nxt = poll_r + 1'b1;
        end
      end else if (hold_inc < limit) begin
        hold_nxt = hold_inc;
      end else begin
        hold_nxt = '0;
        case (phase_r)
          i2cmbe_pkg::PH_ST_A: begin
            sda_nxt = 1'b0; phase_nxt = i2cmbe_pkg::PH_ST_B;
          end
          i2cmbe_pkg::PH_ST_B: begin
            scl_nxt = 1'b0; phase_nxt = i2cmbe_pkg::PH_IDLE; done = 1'b1;
          end
          i2cmbe_pkg::PH_SP_A: begin
            sda_nxt = 1'b1; phase_nxt = i2cmbe_pkg::PH_SP_B;
          end
          i2cmbe_pkg::PH_SP_B: begin
            phase_nxt = i2cmbe_pkg::PH_IDLE; done = 1'b1;
            nack      = (bit_r == i2cmbe_pkg::FAIL_MARK);
          end
          i2cmbe_pkg::PH_WR_SETUP: begin
            scl_nxt = 1'b1; phase_nxt = i2cmbe_pkg::PH_WR_HIGH;
          end
          i2cmbe_pkg::PH_WR_HIGH: begin
            scl_nxt = 1'b0; phase_nxt = i2cmbe_pkg::PH_WR_LOW;
          end
          i2cmbe_pkg::PH_WR_LOW: begin
            bit_nxt = bit_inc;
            if (bit_inc < i2cmbe_pkg::BITS_PER_BYTE) begin
              sda_nxt   = shift_r[7];
              shift_nxt = {shift_r[6:0], 1'b0};
              phase_nxt = i2cmbe_pkg::PH_WR_SETUP;
            end else begin
              drive_nxt = 1'b0; scl_nxt = 1'b1;
              phase_nxt = i2cmbe_pkg::PH_WA_HOLD;
            end
          end
          i2cmbe_pkg::PH_WA_HOLD: begin
            poll_nxt = '0; phase_nxt = i2cmbe_pkg::PH_WA_POLL;
          end
          i2cmbe_pkg::PH_RD_PRE: begin
            scl_nxt = 1'b1; phase_nxt = i2cmbe_pkg::PH_RD_HIGH;
          end
          i2cmbe_pkg::PH_RD_HIGH: begin
            shift_nxt = {shift_r[6:0], item.sda_sample};
            scl_nxt   = 1'b0;
            phase_nxt = i2cmbe_pkg::PH_RD_POST;
          end
          i2cmbe_pkg::PH_RD_POST: begin
            bit_nxt = bit_inc;
            if (bit_inc >= i2cmbe_pkg::BITS_PER_BYTE) begin
              last_read_nxt = shift_r;
              phase_nxt     = i2cmbe_pkg::PH_IDLE;
              done          = 1'b1;
            end else begin
              phase_nxt = i2cmbe_pkg::PH_RD_PRE;
            end
          end
          i2cmbe_pkg::PH_AK_PRE: begin
            sda_nxt = shift_r[0]; scl_nxt = 1'b1;
            phase_nxt = i2cmbe_pkg::PH_AK_HIGH;
          end
          i2cmbe_pkg::PH_AK_HIGH: begin
            scl_nxt = 1'b0; phase_nxt = i2cmbe_pkg::PH_AK_LOW;
          end
          i2cmbe_pkg::PH_AK_LOW: begin
            phase_nxt = i2cmbe_pkg::PH_IDLE; done = 1'b1;
          end
          default: begin
            phase_nxt = i2cmbe_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cmbe_pkg::PH_IDLE;
      bit_r       <= '0;
      shift_r     <= '0;
      hold_r      <= '0;
      poll_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      drive_r     <= 1'b1;
      last_read_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      shift_r     <= shift_nxt;
      hold_r      <= hold_nxt;
      poll_r      <= poll_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      drive_r     <= drive_nxt;
      last_read_r <= last_read_nxt;
    end
  end

  always_comb begin
    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.sda_drive = drive_nxt;
    res.busy_res  = (phase_nxt != i2cmbe_pkg::PH_IDLE);
    res.done_res  = done;
    res.read_data = last_read_nxt;
    res.no_ack    = nack;
    res.rejected  = rej;
  end

  // A finished sequence always leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && done) |=> (phase_r == i2cmbe_pkg::PH_IDLE))
    else $error("sequence completed but engine is not idle");

  // The missing-acknowledge flag only comes with the end of a sequence.
  a_nack_done: assert property (@(posedge clk) disable iff (!rst_n)
    nack |-> done)
    else $error("no_ack raised without done");

  // A rejected command leaves the sequencing state untouched.
  a_rej_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && rej) |=> (phase_r == $past(phase_r) && bit_r == $past(bit_r)
                         && hold_r == $past(hold_r)))
    else $error("rejected command changed the state");

  // The bit counter never passes the end-of-byte mark.
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= i2cmbe_pkg::FAIL_MARK)
    else $error("bit index out of range");

endmodule

// ===== rtl/i2cmbe_out_stage.sv =====
// Result register with a skid entry, so the input side can take one more result during a stall.
module i2cmbe_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  i2cmbe_pkg::res_t push_res,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output i2cmbe_pkg::res_t out_res
);

  logic             main_v_r, main_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  i2cmbe_pkg::res_t main_r, main_nxt;
  i2cmbe_pkg::res_t skid_r, skid_nxt;

  assign can_take  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (out_ready || !main_v_r) begin
      // The front entry drains or is empty: refill it, oldest result first.
      main_v_nxt = skid_v_r || push;
      main_nxt   = skid_v_r ? skid_r : push_res;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  // The skid entry only fills behind a stalled front entry.
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry valid while front entry is empty");

  // No transfer is taken while both entries are occupied.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_v_r)
    else $error("result pushed into a full output stage");

  // A full stage that is not drained stays full.
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_ready) |=> (skid_v_r && main_v_r))
    else $error("buffered result lost during a stall");

endmodule

// ===== rtl/i2c_master_bit_engine_top.sv =====
// Top level of the I2C master bit engine: channels, configuration port and wiring.
//
// Usage: each transfer on in_chan is one item, either a command (start, stop,
// write byte, read byte, send ack) or a tick that advances the running
// sequence by one time unit and carries the sampled SDA level. Every accepted
// item produces exactly one result transfer on out_chan with the SCL/SDA line
// drivers, busy/done, the last read byte and the no_ack/rejected flags.
// The state update happens at the accepting edge; the result is registered
// in the output stage before it shows on out_chan. Throughput is one item per
// cycle while out_chan does not stall. A result register plus one skid entry
// sit in front of out_chan; when the receiver stalls, one more item is still
// taken, after which in_chan.ready drops until out_chan drains. No result is
// dropped. Configuration (half period in ticks, acknowledge timeout in polls)
// is written through cfg_we/cfg_index/cfg_wdata; the user must write it only
// while the engine is idle, which the block itself does not enforce.
// Synchronous reset returns the engine to idle with SCL, SDA and the SDA
// enable high, the read byte cleared, the registers at their defaults and
// the output stage empty.
module i2c_master_bit_engine_top (
  input  logic                              clk,
  input  logic                              rst_n,
  i2cmbe_in_if.sink                         in_chan,
  i2cmbe_out_if.source                      out_chan,
  input  logic                              cfg_we,
  input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cmbe_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  i2cmbe_pkg::item_t item;
  i2cmbe_pkg::res_t  core_res;
  i2cmbe_pkg::res_t  out_res;
  logic              can_take;
  logic              accept;
  logic              out_valid;

  assign in_chan.ready   = can_take;
  assign accept          = in_chan.valid && can_take;
  assign item.kind       = in_chan.kind;
  assign item.data_byte  = in_chan.data_byte;
  assign item.ack_level  = in_chan.ack_level;
  assign item.sda_sample = in_chan.sda_sample;

  i2cmbe_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (core_res)
  );

  i2cmbe_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_res  (core_res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.valid     = out_valid;
  assign out_chan.scl_level = out_res.scl_level;
  assign out_chan.sda_level = out_res.sda_level;
  assign out_chan.sda_drive = out_res.sda_drive;
  assign out_chan.busy_res  = out_res.busy_res;
  assign out_chan.done_res  = out_res.done_res;
  assign out_chan.read_data = out_res.read_data;
  assign out_chan.no_ack    = out_res.no_ack;
  assign out_chan.rejected  = out_res.rejected;

endmodule

// ===== tb/sv/i2c_master_bit_engine_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the I2C master bit engine: directed and random command/tick traffic.
module i2c_master_bit_engine_top_tb;

  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam longint unsigned CYCLE_LIMIT = 2000000;
  localparam longint unsigned HOLD_MAX = (64'd1 << i2cmbe_pkg::HOLD_W) - 64'd1;
  localparam int unsigned MAX_PRINTED = 100;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_we;
  logic [i2cmbe_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [i2cmbe_pkg::CFG_DATA_W-1:0] cfg_wdata;

  i2cmbe_in_if  in_chan ();
  i2cmbe_out_if out_chan ();

  i2c_master_bit_engine_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Engine state as the testbench expects it.
  i2cmbe_pkg::phase_t               ph;
  logic [3:0]                       bit_cnt;
  logic [7:0]                       shifter;
  longint unsigned                  hold_ticks;
  logic [7:0]                       poll_cnt;
  logic                             scl_q;
  logic                             sda_q;
  logic                             drv_q;
  logic [7:0]                       rd_byte;
  logic [i2cmbe_pkg::HALF_W-1:0]    half_cfg;
  logic [i2cmbe_pkg::TIMEOUT_W-1:0] timeout_cfg;

  i2cmbe_pkg::res_t line_states_due[$];
  int unsigned      errors = 0;
  int unsigned      items_sent = 0;
  int unsigned      out_hold = 0;
  longint unsigned  cycles = 0;
  bit               calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    if (errors < MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    errors++;
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want) begin
      report($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // Applies one accepted item to the expected engine state and returns the line state after it.
  function automatic i2cmbe_pkg::res_t advance_engine(input i2cmbe_pkg::item_t it);
    i2cmbe_pkg::res_t r;
    logic             done;
    logic             nack;
    logic             rej;
    longint unsigned  lim;
    done = 1'b0;
    nack = 1'b0;
    rej  = 1'b0;
    lim  = (half_cfg == '0) ? 64'd1 : 64'(half_cfg);
    if (lim > HOLD_MAX) begin
      lim = HOLD_MAX;
    end
    if (it.kind <= i2cmbe_pkg::KIND_ACK) begin
      if (ph != i2cmbe_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        hold_ticks = 0;
        poll_cnt   = '0;
        bit_cnt    = '0;
        case (it.kind)
          i2cmbe_pkg::KIND_START: begin
            drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
            ph = i2cmbe_pkg::PH_ST_A;
          end
          i2cmbe_pkg::KIND_STOP: begin
            drv_q = 1'b1; sda_q = 1'b0; scl_q = 1'b1;
            ph = i2cmbe_pkg::PH_SP_A;
          end
          i2cmbe_pkg::KIND_WRITE: begin
            drv_q = 1'b1; scl_q = 1'b0;
            sda_q   = it.data_byte[7];
            shifter = {it.data_byte[6:0], 1'b0};
            ph = i2cmbe_pkg::PH_WR_SETUP;
          end
          i2cmbe_pkg::KIND_READ: begin
            drv_q   = 1'b0;
            shifter = '0;
            ph = i2cmbe_pkg::PH_RD_PRE;
          end
          default: begin
            drv_q = 1'b1; scl_q = 1'b0;
            shifter = {7'd0, it.ack_level};
            ph = i2cmbe_pkg::PH_AK_PRE;
          end
        endcase
      end
    end else if (it.kind == i2cmbe_pkg::KIND_TICK && ph != i2cmbe_pkg::PH_IDLE) begin
      if (ph == i2cmbe_pkg::PH_WA_POLL) begin
        if (!it.sda_sample) begin
          scl_q = 1'b0;
          ph = i2cmbe_pkg::PH_IDLE;
          done = 1'b1;
        end else if (poll_cnt >= timeout_cfg) begin
          // No acknowledge in time: fall into a stop that reports the failure.
          drv_q = 1'b1; sda_q = 1'b0; scl_q = 1'b1;
          bit_cnt = i2cmbe_pkg::FAIL_MARK;
          hold_ticks = 0;
          ph = i2cmbe_pkg::PH_SP_A;
        end else begin
          poll_cnt = poll_cnt + 8'd1;
        end
      end else begin
        hold_ticks++;
        if (hold_ticks >= lim) begin
          hold_ticks = 0;
          case (ph)
            i2cmbe_pkg::PH_ST_A: begin
              sda_q = 1'b0; ph = i2cmbe_pkg::PH_ST_B;
            end
            i2cmbe_pkg::PH_ST_B: begin
              scl_q = 1'b0; ph = i2cmbe_pkg::PH_IDLE; done = 1'b1;
            end
            i2cmbe_pkg::PH_SP_A: begin
              sda_q = 1'b1; ph = i2cmbe_pkg::PH_SP_B;
            end
            i2cmbe_pkg::PH_SP_B: begin
              ph = i2cmbe_pkg::PH_IDLE; done = 1'b1;
              nack = (bit_cnt == i2cmbe_pkg::FAIL_MARK);
            end
            i2cmbe_pkg::PH_WR_SETUP: begin
              scl_q = 1'b1; ph = i2cmbe_pkg::PH_WR_HIGH;
            end
            i2cmbe_pkg::PH_WR_HIGH: begin
              scl_q = 1'b0; ph = i2cmbe_pkg::PH_WR_LOW;
            end
            i2cmbe_pkg::PH_WR_LOW: begin
              bit_cnt = bit_cnt + 4'd1;
              if (bit_cnt < i2cmbe_pkg::BITS_PER_BYTE) begin
                sda_q   = shifter[7];
                shifter = {shifter[6:0], 1'b0};
                ph = i2cmbe_pkg::PH_WR_SETUP;
              end else begin
                drv_q = 1'b0; scl_q = 1'b1;
                ph = i2cmbe_pkg::PH_WA_HOLD;
              end
            end
            i2cmbe_pkg::PH_WA_HOLD: begin
              poll_cnt = '0; ph = i2cmbe_pkg::PH_WA_POLL;
            end
            i2cmbe_pkg::PH_RD_PRE: begin
              scl_q = 1'b1; ph = i2cmbe_pkg::PH_RD_HIGH;
            end
            i2cmbe_pkg::PH_RD_HIGH: begin
              shifter = {shifter[6:0], it.sda_sample};
              scl_q = 1'b0;
              ph = i2cmbe_pkg::PH_RD_POST;
            end
            i2cmbe_pkg::PH_RD_POST: begin
              bit_cnt = bit_cnt + 4'd1;
              if (bit_cnt >= i2cmbe_pkg::BITS_PER_BYTE) begin
                rd_byte = shifter;
                ph = i2cmbe_pkg::PH_IDLE; done = 1'b1;
              end else begin
                ph = i2cmbe_pkg::PH_RD_PRE;
              end
            end
            i2cmbe_pkg::PH_AK_PRE: begin
              sda_q = shifter[0]; scl_q = 1'b1;
              ph = i2cmbe_pkg::PH_AK_HIGH;
            end
            i2cmbe_pkg::PH_AK_HIGH: begin
              scl_q = 1'b0; ph = i2cmbe_pkg::PH_AK_LOW;
            end
            i2cmbe_pkg::PH_AK_LOW: begin
              ph = i2cmbe_pkg::PH_IDLE; done = 1'b1;
            end
            default: begin
              ph = i2cmbe_pkg::PH_IDLE;
            end
          endcase
        end
      end
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.sda_drive = drv_q;
    r.busy_res  = (ph != i2cmbe_pkg::PH_IDLE);
    r.done_res  = done;
    r.read_data = rd_byte;
    r.no_ack    = nack;
    r.rejected  = rej;
    return r;
  endfunction

  // Result side: random stalls per transfer, each result checked against the oldest expectation.
  always @(posedge clk) begin
    i2cmbe_pkg::res_t want;
    if (!rst_n) begin
      out_hold = 0;
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (line_states_due.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = line_states_due.pop_front();
          compare_field("scl_level", out_chan.scl_level, want.scl_level);
          compare_field("sda_level", out_chan.sda_level, want.sda_level);
          compare_field("sda_drive", out_chan.sda_drive, want.sda_drive);
          compare_field("busy_res", out_chan.busy_res, want.busy_res);
          compare_field("done_res", out_chan.done_res, want.done_res);
          compare_field("read_data", out_chan.read_data, want.read_data);
          compare_field("no_ack", out_chan.no_ack, want.no_ack);
          compare_field("rejected", out_chan.rejected, want.rejected);
        end
        out_hold = calm ? 0 : $urandom_range(0, 8);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_chan.ready <= (out_hold == 0);
    end
  end

  task automatic send_item(input logic [2:0] kind, input logic [7:0] data,
                           input logic ack, input logic sda);
    int unsigned       gap;
    i2cmbe_pkg::item_t it;
    gap = calm ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.kind       <= kind;
    in_chan.data_byte  <= data;
    in_chan.ack_level  <= ack;
    in_chan.sda_sample <= sda;
    it.kind       = kind;
    it.data_byte  = data;
    it.ack_level  = ack;
    it.sda_sample = sda;
    do @(posedge clk); while (!in_chan.ready);
    line_states_due.push_back(advance_engine(it));
    items_sent++;
  endtask

  // Ticks until the engine is idle. ack_pct is the chance that a poll sees the acknowledge,
  // noise_pct the chance of a stray command or unused kind between ticks.
  task automatic run_ticks(input int unsigned ack_pct, input int unsigned noise_pct);
    logic sda;
    while (ph != i2cmbe_pkg::PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        if (ph == i2cmbe_pkg::PH_WA_POLL) begin
          sda = ($urandom_range(0, 99) >= ack_pct);
        end else begin
          sda = 1'($urandom);
        end
        send_item(i2cmbe_pkg::KIND_TICK, 8'($urandom), 1'($urandom), sda);
      end
    end
  endtask

  task automatic run_sequence(input logic [2:0] kind, input logic [7:0] data, input logic ack,
                              input int unsigned ack_pct, input int unsigned noise_pct);
    send_item(kind, data, ack, 1'($urandom));
    run_ticks(ack_pct, noise_pct);
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (line_states_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers are written one after the other while the engine sits idle.
  task automatic set_config(input int unsigned half, input int unsigned polls);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= i2cmbe_pkg::REG_HALF_PERIOD;
    cfg_wdata <= i2cmbe_pkg::CFG_DATA_W'(half);
    @(posedge clk);
    half_cfg = i2cmbe_pkg::HALF_W'(half);
    cfg_index <= i2cmbe_pkg::REG_ACK_TIMEOUT;
    cfg_wdata <= i2cmbe_pkg::CFG_DATA_W'(polls);
    @(posedge clk);
    timeout_cfg = i2cmbe_pkg::TIMEOUT_W'(polls);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_item(i2cmbe_pkg::KIND_TICK, 8'h00, 1'b0, 1'b1);
    send_item(3'd6, 8'hFF, 1'b1, 1'b0);
    send_item(3'd7, 8'h3C, 1'b0, 1'b1);
    run_sequence(i2cmbe_pkg::KIND_START, 8'h00, 1'b0, 100, 0);
    run_sequence(i2cmbe_pkg::KIND_WRITE, 8'hA5, 1'b0, 100, 0);
    run_sequence(i2cmbe_pkg::KIND_ACK, 8'hFF, 1'b1, 100, 0);
    run_sequence(i2cmbe_pkg::KIND_STOP, 8'h00, 1'b0, 100, 0);
  endtask

  task automatic test_busy_rejects();
    send_item(i2cmbe_pkg::KIND_START, 8'h00, 1'b0, 1'b0);
    send_item(i2cmbe_pkg::KIND_START, 8'h11, 1'b1, 1'b1);
    send_item(i2cmbe_pkg::KIND_STOP, 8'h22, 1'b0, 1'b0);
    send_item(i2cmbe_pkg::KIND_WRITE, 8'hFF, 1'b1, 1'b1);
    send_item(i2cmbe_pkg::KIND_READ, 8'h00, 1'b0, 1'b0);
    send_item(i2cmbe_pkg::KIND_ACK, 8'h80, 1'b1, 1'b1);
    run_ticks(100, 0);
  endtask

  // Half period zero acts as one; a zero timeout fails the write on its first high poll.
  task automatic test_zero_settings();
    set_config(0, 0);
    run_sequence(i2cmbe_pkg::KIND_WRITE, 8'hFF, 1'b1, 0, 0);
    run_sequence(i2cmbe_pkg::KIND_WRITE, 8'h00, 1'b0, 100, 0);
    run_sequence(i2cmbe_pkg::KIND_READ, 8'h00, 1'b0, 100, 0);
    run_sequence(i2cmbe_pkg::KIND_START, 8'h00, 1'b0, 100, 0);
  endtask

  task automatic test_timeout_limit();
    set_config(1, 255);
    run_sequence(i2cmbe_pkg::KIND_WRITE, 8'h81, 1'b0, 0, 0);
    run_sequence(i2cmbe_pkg::KIND_WRITE, 8'h7E, 1'b1, 2, 0);
  endtask

  task automatic test_long_half_period();
    calm = 1'b1;
    set_config(48, 1);
    run_sequence(i2cmbe_pkg::KIND_START, 8'h00, 1'b0, 100, 0);
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int unsigned phase_first;
    int unsigned half;
    int unsigned polls;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      half  = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      polls = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
      set_config(half, polls);
      calm = ($urandom_range(0, 3) == 0);
      phase_first = items_sent;
      while (items_sent - phase_first < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) begin
          run_sequence(3'($urandom_range(0, 4)), 8'($urandom), 1'($urandom),
                       $urandom_range(0, 100), $urandom_range(0, 8));
        end else begin
          send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 1'($urandom));
          run_ticks($urandom_range(0, 100), 0);
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    in_chan.valid      <= 1'b0;
    in_chan.kind       <= i2cmbe_pkg::KIND_TICK;
    in_chan.data_byte  <= 8'h00;
    in_chan.ack_level  <= 1'b0;
    in_chan.sda_sample <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= i2cmbe_pkg::REG_HALF_PERIOD;
    cfg_wdata          <= '0;
    rst_n              <= 1'b0;
    ph          = i2cmbe_pkg::PH_IDLE;
    bit_cnt     = '0;
    shifter     = '0;
    hold_ticks  = 0;
    poll_cnt    = '0;
    scl_q       = 1'b1;
    sda_q       = 1'b1;
    drv_q       = 1'b1;
    rd_byte     = '0;
    half_cfg    = i2cmbe_pkg::HALF_RESET;
    timeout_cfg = i2cmbe_pkg::TIMEOUT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_busy_rejects();
    test_zero_settings();
    test_timeout_limit();
    test_long_half_period();
    test_random_traffic();

    settle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
